FILE: hdl/iklp_pkg.sv
// Shared types and constants for the integer-key linear-probe hash table.
// Request and response payload structs, request and slot-tag codes, mixer constants.
// No dependencies.
package iklp_pkg;

  localparam int unsigned SLOTS_DEF = 1024;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned VAL_W     = 64;
  localparam int unsigned LIVE_W    = 11;

  // Request codes; code 3 is unused and leaves the table untouched.
  localparam logic [1:0] REQ_GET = 2'd0;
  localparam logic [1:0] REQ_PUT = 2'd1;
  localparam logic [1:0] REQ_DEL = 2'd2;

  // Slot state tags.
  localparam logic [1:0] TAG_EMPTY = 2'd0;
  localparam logic [1:0] TAG_LIVE  = 2'd1;
  localparam logic [1:0] TAG_TOMB  = 2'd2;

  localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned MIX_SHIFT = 33;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [KEY_W-1:0] key;
    logic [VAL_W-1:0]        value;
  } iklp_req_t;

  typedef struct packed {
    logic              hit;
    logic [VAL_W-1:0]  read_value;
    logic              status;
    logic [LIVE_W-1:0] live_entries;
  } iklp_rsp_t;

  typedef struct packed {
    logic [1:0]       tag;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } iklp_slot_t;

endpackage

FILE: hdl/int_key_linear_probe_hash_table.sv
// Integer-key hash table with open addressing and linear probing.
// Depends on iklp_pkg for payload structs, codes and mixer constants.
//
// Usage: a request (get, put or delete with key and value) enters on the in channel
// when in_valid_i is high and in_stall_o is low. One response per request leaves on
// the out channel when out_valid_o is high and out_stall_i is low.
// The key is mixed by a shared 32x32 multiplier, three partial products per 64-bit
// multiply. When SLOTS is not a power of two the home slot is then reduced:
// fold the hash bytewise, multiply by the reciprocal, correct once.
// The probe reads one slot per cycle from a single-port-read slot memory.
// The response to a request is registered when its probe stops and the output
// register is free; the next request is taken in the cycle after that. Only one
// request is in flight at a time. After reset the slot memory is swept to empty,
// one slot per cycle, during which in_stall_o stays high.
// A waiting response sits in the output register, so a new request is accepted
// while it is stalled; if the following response is ready before the first is taken,
// the probe holds with no table update until the output register frees.
module int_key_linear_probe_hash_table #(
  parameter int unsigned SLOTS = iklp_pkg::SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  iklp_pkg::iklp_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output iklp_pkg::iklp_rsp_t out_rsp_o
);

  localparam int unsigned IDX_W   = $clog2(SLOTS);
  localparam int unsigned CNT_W   = $clog2(SLOTS + 1);
  localparam int unsigned SUM_W   = IDX_W + 11;
  localparam bit          IS_POW2 = (SLOTS & (SLOTS - 1)) == 0;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  // Weight of each hash byte, 2^(8*i) mod SLOTS, packed one per IDX_W bits.
  function automatic logic [8*IDX_W-1:0] fold_weights();
    logic [8*IDX_W-1:0] ws;
    longint unsigned    w;
    ws = '0;
    w  = 1;
    for (int i = 0; i < 8; i++) begin
      ws[i*IDX_W +: IDX_W] = IDX_W'(w);
      w = (w * 256) % SLOTS;
    end
    return ws;
  endfunction

  localparam logic [8*IDX_W-1:0] FOLD_W    = fold_weights();
  localparam logic [SUM_W-1:0]   MOD_DIV   = SUM_W'(SLOTS);
  localparam logic [SUM_W-1:0]   MOD_RECIP = SUM_W'((64'd1 << SUM_W) / SLOTS);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_HASH  = 5'b00100,
    ST_MOD   = 5'b01000,
    ST_PROBE = 5'b10000
  } state_e;

  function automatic logic [63:0] xor_shift(input logic [63:0] h);
    xor_shift = h ^ (h >> iklp_pkg::MIX_SHIFT);
  endfunction

  state_e state_q, state_d;

  logic [IDX_W-1:0] clr_q, clr_d;
  logic [63:0]      mop_q, mop_d;
  logic [63:0]      acc_q, acc_d;
  logic [1:0]       mstep_q, mstep_d;
  logic             mround_q, mround_d;
  logic [1:0]       bit_q, bit_d;
  logic [SUM_W-1:0] msum_q, msum_d;
  logic [SUM_W-1:0] mquo_q, mquo_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic [IDX_W-1:0] n_q, n_d;
  logic             tomb_vld_q, tomb_vld_d;
  logic [IDX_W-1:0] tomb_pos_q, tomb_pos_d;
  logic [1:0]       req_q, req_d;
  logic [63:0]      key_q, key_d;
  logic [63:0]      val_q, val_d;
  logic [CNT_W-1:0] live_q, live_d;
  logic             out_valid_q, out_valid_d;
  iklp_pkg::iklp_rsp_t rsp_q, rsp_d;

  iklp_pkg::iklp_slot_t slot_mem_q [SLOTS];
  iklp_pkg::iklp_slot_t rdata_q;
  iklp_pkg::iklp_slot_t wr_data;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] mix_c;
  logic [SUM_W-1:0]   mod_sum;
  logic [2*SUM_W-1:0] mod_prod;
  logic [SUM_W-1:0]   mod_rem;
  logic [IDX_W-1:0]   mod_pos;
  logic [IDX_W-1:0] pos_inc;
  logic in_acc, out_free;
  logic is_match, is_empty, is_last, stop, tomb_now, have_tomb;
  logic [IDX_W-1:0] tomb_at;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // Shared multiplier: lo*lo, hi*lo, lo*hi give the low 64 bits of the product.
  assign mix_c = mround_q ? iklp_pkg::MIX_C2 : iklp_pkg::MIX_C1;
  assign mul_a = (mstep_q == 2'd1) ? mop_q[63:32] : mop_q[31:0];
  assign mul_b = (mstep_q == 2'd2) ? mix_c[63:32] : mix_c[31:0];
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Home slot for a non-power-of-two table: the folded sum is congruent to the hash,
  // the reciprocal quotient is exact or one short, so one subtraction corrects it.
  always_comb begin
    mod_sum = '0;
    for (int i = 0; i < 8; i++) begin
      mod_sum = mod_sum + SUM_W'(mop_q[8*i +: 8]) * SUM_W'(FOLD_W[i*IDX_W +: IDX_W]);
    end
  end

  assign mod_prod = (2*SUM_W)'(msum_q) * (2*SUM_W)'(MOD_RECIP);
  assign mod_rem  = msum_q - mquo_q * MOD_DIV;
  assign mod_pos  = (mod_rem >= MOD_DIV) ? IDX_W'(mod_rem - MOD_DIV) : IDX_W'(mod_rem);

  assign pos_inc   = (pos_q == LAST_IDX) ? '0 : pos_q + 1'b1;
  assign is_match  = (rdata_q.tag == iklp_pkg::TAG_LIVE) && (rdata_q.key == key_q);
  assign is_empty  = (rdata_q.tag == iklp_pkg::TAG_EMPTY);
  assign is_last   = (n_q == LAST_IDX);
  assign stop      = is_match || is_empty || is_last;
  assign tomb_now  = (rdata_q.tag == iklp_pkg::TAG_TOMB) && !tomb_vld_q;
  assign have_tomb = tomb_vld_q || tomb_now;
  assign tomb_at   = tomb_vld_q ? tomb_pos_q : pos_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    mop_d       = mop_q;
    acc_d       = acc_q;
    mstep_d     = mstep_q;
    mround_d    = mround_q;
    bit_d       = bit_q;
    msum_d      = msum_q;
    mquo_d      = mquo_q;
    pos_d       = pos_q;
    n_d         = n_q;
    tomb_vld_d  = tomb_vld_q;
    tomb_pos_d  = tomb_pos_q;
    req_d       = req_q;
    key_d       = key_q;
    val_d       = val_q;
    live_d      = live_q;
    out_valid_d = out_valid_q && out_stall_i;
    rsp_d       = rsp_q;
    wr_en       = 1'b0;
    wr_addr     = pos_q;
    wr_data     = '{tag: iklp_pkg::TAG_LIVE, key: key_q, value: val_q};

    unique case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '{tag: iklp_pkg::TAG_EMPTY, key: '0, value: '0};
        clr_d   = clr_q + 1'b1;
        if (clr_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          req_d    = in_req_i.req_type;
          key_d    = in_req_i.key;
          val_d    = in_req_i.value;
          mop_d    = xor_shift(in_req_i.key);
          mstep_d  = 2'd0;
          mround_d = 1'b0;
          state_d  = ST_HASH;
        end
      end
      ST_HASH: begin
        mstep_d = mstep_q + 1'b1;
        case (mstep_q) inside
          2'd0: acc_d = mul_p;
          2'd1, 2'd2: acc_d = acc_q + {mul_p[31:0], 32'b0};
          default: begin
            mop_d    = xor_shift(acc_q);
            mround_d = 1'b1;
            if (mround_q) begin
              n_d        = '0;
              tomb_vld_d = 1'b0;
              if (IS_POW2) begin
                pos_d   = mop_d[IDX_W-1:0];
                state_d = ST_PROBE;
              end else begin
                bit_d   = '0;
                state_d = ST_MOD;
              end
            end
          end
        endcase
      end
      ST_MOD: begin
        bit_d = bit_q + 1'b1;
        case (bit_q)
          2'd0: msum_d = mod_sum;
          2'd1: mquo_d = mod_prod[2*SUM_W-1:SUM_W];
          default: begin
            pos_d   = mod_pos;
            state_d = ST_PROBE;
          end
        endcase
      end
      ST_PROBE: begin
        if (!stop) begin
          pos_d = pos_inc;
          n_d   = n_q + 1'b1;
          if (tomb_now) begin
            tomb_vld_d = 1'b1;
            tomb_pos_d = pos_q;
          end
        end else if (out_free) begin
          rsp_d = '0;
          case (req_q)
            iklp_pkg::REQ_GET: begin
              rsp_d.hit        = is_match;
              rsp_d.read_value = is_match ? rdata_q.value : '0;
            end
            iklp_pkg::REQ_PUT: begin
              if (is_match) begin
                rsp_d.hit = 1'b1;
                wr_en     = 1'b1;
              end else if (have_tomb) begin
                wr_en   = 1'b1;
                wr_addr = tomb_at;
                live_d  = live_q + 1'b1;
              end else if (is_empty) begin
                wr_en  = 1'b1;
                live_d = live_q + 1'b1;
              end else begin
                rsp_d.status = 1'b1;
              end
            end
            iklp_pkg::REQ_DEL: begin
              if (is_match) begin
                rsp_d.hit   = 1'b1;
                wr_en       = 1'b1;
                wr_data.tag = iklp_pkg::TAG_TOMB;
                live_d      = live_q - 1'b1;
              end
            end
            default: ;
          endcase
          rsp_d.live_entries = iklp_pkg::LIVE_W'(live_d);
          out_valid_d        = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      mstep_q     <= '0;
      mround_q    <= 1'b0;
      bit_q       <= '0;
      n_q         <= '0;
      tomb_vld_q  <= 1'b0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      mstep_q     <= mstep_d;
      mround_q    <= mround_d;
      bit_q       <= bit_d;
      n_q         <= n_d;
      tomb_vld_q  <= tomb_vld_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mop_q      <= mop_d;
    acc_q      <= acc_d;
    msum_q     <= msum_d;
    mquo_q     <= mquo_d;
    pos_q      <= pos_d;
    tomb_pos_q <= tomb_pos_d;
    req_q      <= req_d;
    key_q      <= key_d;
    val_q      <= val_d;
    rsp_q      <= rsp_d;
  end

  // Slot memory: one write port, one registered read port addressed by the next probe slot.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= slot_mem_q[pos_d];
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

FILE: hdl/iklp_checker.sv
// Port-level checks for the integer-key linear-probe hash table.
// Depends on iklp_pkg; bound to int_key_linear_probe_hash_table below.
module iklp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input iklp_pkg::iklp_req_t in_req_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input iklp_pkg::iklp_rsp_t out_rsp_o
);

  // A response that is stalled stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("response dropped while stalled");

  // One request in flight: an accepted request blocks the input next cycle.
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request accepted during hashing");

  // A failed put never reports a hit.
  a_status_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.status && out_rsp_o.hit))
    else $error("full status together with hit");

  // Read data is zero unless the key was found.
  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.hit |-> out_rsp_o.read_value == '0)
    else $error("read value without hit");

endmodule

bind int_key_linear_probe_hash_table iklp_checker u_iklp_checker (.*);

FILE: dv/tb.sv
// Self-checking bench for the integer-key linear-probe hash table.
// Depends on iklp_pkg and int_key_linear_probe_hash_table; keeps a shadow table
// and compares every response in order.
module tb;

  localparam int unsigned SLOTS       = iklp_pkg::SLOTS_DEF;
  localparam int unsigned POOL_SIZE   = 40;
  localparam int unsigned CYCLE_LIMIT = 8_000_000;
  localparam logic [1:0]  REQ_SPARE   = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  iklp_pkg::iklp_req_t in_req_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  iklp_pkg::iklp_rsp_t out_rsp_o;

  int_key_linear_probe_hash_table #(.SLOTS(SLOTS)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the table
  logic [1:0]  shadow_tag [SLOTS];
  logic [63:0] shadow_key [SLOTS];
  logic [63:0] shadow_val [SLOTS];
  int unsigned shadow_live;

  iklp_pkg::iklp_rsp_t awaited_rsp [$];
  logic [63:0]         key_pool [POOL_SIZE];
  int unsigned         mismatches;
  bit                  steady;

  function automatic logic [63:0] mix64(input logic [63:0] h);
    h = h ^ (h >> iklp_pkg::MIX_SHIFT);
    h = h * iklp_pkg::MIX_C1;
    h = h ^ (h >> iklp_pkg::MIX_SHIFT);
    h = h * iklp_pkg::MIX_C2;
    h = h ^ (h >> iklp_pkg::MIX_SHIFT);
    return h;
  endfunction

  function automatic int home_slot(input logic [63:0] k);
    return int'(mix64(k) % 64'(SLOTS));
  endfunction

  function automatic logic [63:0] fresh_word();
    return {$urandom(), $urandom()};
  endfunction

  // Search for a key whose home slot is the given one
  function automatic logic [63:0] key_homed_at(input int slot);
    logic [63:0] k;
    k = fresh_word();
    while (home_slot(k) != slot) k = fresh_word();
    return k;
  endfunction

  // Apply one request to the shadow table and return the response it owes
  function automatic iklp_pkg::iklp_rsp_t apply_request(input iklp_pkg::iklp_req_t r);
    iklp_pkg::iklp_rsp_t rsp;
    logic [63:0]         k;
    int                  pos;
    int                  tomb;
    int                  empty_at;
    int                  found;
    rsp      = '0;
    k        = r.key;
    pos      = home_slot(k);
    tomb     = -1;
    empty_at = -1;
    found    = -1;
    for (int n = 0; n < SLOTS; n++) begin
      if (shadow_tag[pos] == iklp_pkg::TAG_LIVE && shadow_key[pos] == k) begin
        found = pos;
        break;
      end
      if (shadow_tag[pos] == iklp_pkg::TAG_TOMB && tomb < 0) tomb = pos;
      if (shadow_tag[pos] == iklp_pkg::TAG_EMPTY) begin
        empty_at = pos;
        break;
      end
      pos = (pos + 1) % SLOTS;
    end
    case (r.req_type)
      iklp_pkg::REQ_GET: begin
        if (found >= 0) begin
          rsp.hit        = 1'b1;
          rsp.read_value = shadow_val[found];
        end
      end
      iklp_pkg::REQ_PUT: begin
        if (found >= 0) begin
          rsp.hit           = 1'b1;
          shadow_val[found] = r.value;
        end else if (tomb >= 0 || empty_at >= 0) begin
          // reuse the first tombstone before the empty slot
          pos             = (tomb >= 0) ? tomb : empty_at;
          shadow_tag[pos] = iklp_pkg::TAG_LIVE;
          shadow_key[pos] = k;
          shadow_val[pos] = r.value;
          shadow_live++;
        end else begin
          rsp.status = 1'b1;
        end
      end
      iklp_pkg::REQ_DEL: begin
        if (found >= 0) begin
          rsp.hit           = 1'b1;
          shadow_tag[found] = iklp_pkg::TAG_TOMB;
          if (shadow_live > 0) shadow_live--;
        end
      end
      default: ;
    endcase
    rsp.live_entries = shadow_live[iklp_pkg::LIVE_W-1:0];
    return rsp;
  endfunction

  function automatic void flag_error(input string what, input logic [63:0] want,
                                     input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at %0t: expected %h, got %h", what, $time, want, got);
  endfunction

  // Response checker
  always @(posedge clk_i) begin : rsp_check
    iklp_pkg::iklp_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_rsp.size() == 0) begin
        flag_error("unexpected response", '0, out_rsp_o.read_value);
      end else begin
        want = awaited_rsp.pop_front();
        if (out_rsp_o.hit !== want.hit)
          flag_error("hit", 64'(want.hit), 64'(out_rsp_o.hit));
        if (out_rsp_o.read_value !== want.read_value)
          flag_error("read_value", want.read_value, out_rsp_o.read_value);
        if (out_rsp_o.status !== want.status)
          flag_error("status", 64'(want.status), 64'(out_rsp_o.status));
        if (out_rsp_o.live_entries !== want.live_entries)
          flag_error("live_entries", 64'(want.live_entries), 64'(out_rsp_o.live_entries));
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i) out_stall_i <= !steady && ($urandom_range(99) < 23);

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic send_req(input logic [1:0] kind, input logic [63:0] key,
                          input logic [63:0] value);
    iklp_pkg::iklp_req_t r;
    r.req_type = kind;
    r.key      = key;
    r.value    = value;
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    awaited_rsp.push_back(apply_request(r));
  endtask

  // Hold off until every owed response has come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_rsp.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed();
    logic [63:0] max_key;
    logic [63:0] min_key;
    max_key = {1'b0, {63{1'b1}}};
    min_key = {1'b1, 63'd0};
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = min_key;
    key_pool[3] = max_key;
    // keys homed at the last slots, so their probes wrap
    for (int i = 4; i < 8; i++) key_pool[i] = key_homed_at(SLOTS - 1);
    for (int i = 8; i < 12; i++) key_pool[i] = key_homed_at(SLOTS - 2);
    for (int i = 12; i < POOL_SIZE; i++) key_pool[i] = fresh_word();

    send_req(iklp_pkg::REQ_GET, '0, fresh_word());
    send_req(iklp_pkg::REQ_PUT, '0, '1);
    send_req(iklp_pkg::REQ_PUT, '1, '0);
    send_req(iklp_pkg::REQ_PUT, min_key, fresh_word());
    send_req(iklp_pkg::REQ_PUT, max_key, fresh_word());
    for (int i = 0; i < 4; i++) send_req(iklp_pkg::REQ_GET, key_pool[i], '1);
    send_req(iklp_pkg::REQ_PUT, '0, fresh_word());
    send_req(iklp_pkg::REQ_DEL, '1, '0);
    send_req(iklp_pkg::REQ_DEL, '1, '0);
    send_req(iklp_pkg::REQ_GET, '1, '0);
    send_req(iklp_pkg::REQ_PUT, '1, '1);
    send_req(REQ_SPARE, '0, '1);
    // wrap-around cluster: tombstone skip, no duplicate on re-put, tombstone reuse
    for (int i = 4; i < 7; i++) send_req(iklp_pkg::REQ_PUT, key_pool[i], fresh_word());
    send_req(iklp_pkg::REQ_DEL, key_pool[4], '0);
    send_req(iklp_pkg::REQ_GET, key_pool[6], '0);
    send_req(iklp_pkg::REQ_PUT, key_pool[5], fresh_word());
    send_req(iklp_pkg::REQ_PUT, key_pool[7], fresh_word());
    send_req(iklp_pkg::REQ_DEL, key_pool[5], '0);
    send_req(iklp_pkg::REQ_DEL, key_pool[6], '0);
  endtask

  task automatic test_random_mix(input int count);
    logic [1:0]  kind;
    logic [63:0] key;
    logic [63:0] value;
    int          roll;
    for (int i = 0; i < count; i++) begin
      steady = (i >= count / 3 && i < count / 3 + 120);
      if (i % 150 == 149) wait_drained();
      roll = $urandom_range(99);
      if (roll < 3)       kind = REQ_SPARE;
      else if (roll < 38) kind = iklp_pkg::REQ_GET;
      else if (roll < 75) kind = iklp_pkg::REQ_PUT;
      else                kind = iklp_pkg::REQ_DEL;
      key = ($urandom_range(99) < 75) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                      : fresh_word();
      roll = $urandom_range(99);
      if (roll < 5)       value = '0;
      else if (roll < 10) value = '1;
      else                value = fresh_word();
      send_req(kind, key, value);
    end
    steady = 1'b0;
  endtask

  task automatic test_fill_to_full();
    wait_drained();
    while (shadow_live < SLOTS) send_req(iklp_pkg::REQ_PUT, fresh_word(), fresh_word());
  endtask

  task automatic test_full_table();
    logic [63:0] victim;
    wait_drained();
    send_req(iklp_pkg::REQ_PUT, fresh_word(), fresh_word());
    send_req(iklp_pkg::REQ_PUT, fresh_word(), '1);
    send_req(iklp_pkg::REQ_GET, fresh_word(), '0);
    send_req(iklp_pkg::REQ_DEL, fresh_word(), '0);
    send_req(iklp_pkg::REQ_PUT, key_pool[0], '1);
    victim = shadow_key[$urandom_range(SLOTS - 1)];
    send_req(iklp_pkg::REQ_DEL, victim, '0);
    send_req(iklp_pkg::REQ_PUT, fresh_word(), fresh_word());
    send_req(iklp_pkg::REQ_PUT, fresh_word(), fresh_word());
    send_req(iklp_pkg::REQ_GET, victim, '0);
  endtask

  initial begin
    mismatches  = 0;
    steady      = 1'b0;
    shadow_live = 0;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_tag[i] = iklp_pkg::TAG_EMPTY;
      shadow_key[i] = '0;
      shadow_val[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_mix(640);
    test_fill_to_full();
    test_full_table();

    wait_drained();
    repeat (SLOTS + 32) @(posedge clk_i);
    if (mismatches == 0 && awaited_rsp.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/iklp_pkg.sv
hdl/int_key_linear_probe_hash_table.sv
hdl/iklp_checker.sv
dv/tb.sv
